// ===== rtl/core/gcsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcsc_pkg: command stream checker shared types
// Transfer payloads, status codes and opcode range bounds.
// ----------------------------------------------------------------------------
package gcsc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned OpW     = 8;
  localparam int unsigned LenW    = 4;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_TRUNCATED   = 2'd2
  } status_e;

  localparam logic [OpW-1:0] OpPolyLo  = 8'h20;
  localparam logic [OpW-1:0] OpPolyHi  = 8'h3f;
  localparam logic [OpW-1:0] OpLineLo  = 8'h40;
  localparam logic [OpW-1:0] OpLineHi  = 8'h47;
  localparam logic [OpW-1:0] OpPlineLo = 8'h50;
  localparam logic [OpW-1:0] OpPlineHi = 8'h57;
  localparam logic [OpW-1:0] OpRectLo  = 8'h60;
  localparam logic [OpW-1:0] OpRectHi  = 8'h7f;
  localparam logic [OpW-1:0] OpEnvLo   = 8'he1;
  localparam logic [OpW-1:0] OpEnvHi   = 8'he6;
  localparam logic [OpW-1:0] OpNop     = 8'h00;
  localparam logic [OpW-1:0] OpFill    = 8'h02;
  localparam logic [OpW-1:0] OpCopy    = 8'h80;
  localparam logic [OpW-1:0] RectSizeM = 8'h18;

  localparam logic [LenW-1:0] MaxLen = 4'd12;

  typedef struct packed {
    logic [WordW-1:0] command_word;
    logic             last_word;
  } in_t;

  typedef struct packed {
    logic            is_header;
    logic [LenW-1:0] command_length;
    status_e         status;
    logic            stream_done;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/core/gcsc_len_dec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcsc_len_dec: opcode length decoder
// Maps a header opcode to the command's total word count, 0 if unknown.
// ----------------------------------------------------------------------------
module gcsc_len_dec (
  input  wire logic [gcsc_pkg::OpW-1:0]  opcode_i,
  output logic      [gcsc_pkg::LenW-1:0] length_o
);

  logic [2:0]                vtx;
  logic [1:0]                per_vtx;
  logic [gcsc_pkg::LenW-1:0] poly_len;
  logic [gcsc_pkg::LenW-1:0] rect_len;

  always_comb begin
    vtx      = opcode_i[3] ? 3'd4 : 3'd3;
    per_vtx  = 2'd1 + {1'b0, opcode_i[2]} + {1'b0, opcode_i[4]};
    poly_len = 4'd1 + 4'(vtx * per_vtx) - {3'd0, opcode_i[4]};
    rect_len = 4'd2 + {3'd0, opcode_i[2]}
             + {3'd0, ((opcode_i & gcsc_pkg::RectSizeM) == '0)};
  end

  always_comb begin
    unique case (opcode_i) inside
      [gcsc_pkg::OpPolyLo:gcsc_pkg::OpPolyHi]:   length_o = poly_len;
      [gcsc_pkg::OpLineLo:gcsc_pkg::OpLineHi]:   length_o = 4'd3;
      [gcsc_pkg::OpPlineLo:gcsc_pkg::OpPlineHi]: length_o = 4'd4;
      [gcsc_pkg::OpRectLo:gcsc_pkg::OpRectHi]:   length_o = rect_len;
      [gcsc_pkg::OpEnvLo:gcsc_pkg::OpEnvHi]:     length_o = 4'd1;
      gcsc_pkg::OpNop:                           length_o = 4'd1;
      gcsc_pkg::OpFill:                          length_o = 4'd3;
      gcsc_pkg::OpCopy:                          length_o = 4'd4;
      default:                                   length_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/gcsc_frame.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcsc_frame: command framing tracker
// Holds the owed parameter word count and the sticky verdict of the stream.
// ----------------------------------------------------------------------------
module gcsc_frame (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      advance_i,
  input  wire gcsc_pkg::in_t             data_i,
  input  wire logic [gcsc_pkg::LenW-1:0] dec_len_i,
  output gcsc_pkg::out_t                 result_o
);

  logic [gcsc_pkg::LenW-1:0] remain_q, remain_d, remain_n;
  gcsc_pkg::status_e         err_q, err_d, err_n;
  logic                      header;
  logic [gcsc_pkg::LenW-1:0] length;

  always_comb begin
    remain_n = remain_q;
    err_n    = err_q;
    header   = 1'b0;
    length   = '0;
    if (err_q == gcsc_pkg::ST_OK) begin
      if (remain_q != '0) begin
        remain_n = remain_q - 4'd1;
      end else begin
        header = 1'b1;
        length = dec_len_i;
        if (dec_len_i == '0) begin
          err_n = gcsc_pkg::ST_UNSUPPORTED;
        end else begin
          remain_n = dec_len_i - 4'd1;
        end
      end
      if (data_i.last_word && err_n == gcsc_pkg::ST_OK && remain_n != '0) begin
        err_n = gcsc_pkg::ST_TRUNCATED;
      end
    end
    result_o.is_header      = header;
    result_o.command_length = length;
    result_o.status         = err_n;
    result_o.stream_done    = data_i.last_word;
    remain_d = data_i.last_word ? '0 : remain_n;
    err_d    = data_i.last_word ? gcsc_pkg::ST_OK : err_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      err_q    <= gcsc_pkg::ST_OK;
    end else if (advance_i) begin
      remain_q <= remain_d;
      err_q    <= err_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gpu_command_stream_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpu_command_stream_checker: graphics command stream framing checker
// Each input transfer passes through the input register, then the result register.
// Throughput: one word per cycle while the result side does not stall.
// Stall on the result side propagates back through the input register.
// Reset (async, active low) empties both registers and clears framing state.
// ----------------------------------------------------------------------------
module gpu_command_stream_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire gcsc_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output gcsc_pkg::out_t      out_data_o
);

  logic                      in_valid_q;
  gcsc_pkg::in_t             in_data_q;
  logic                      out_valid_q;
  gcsc_pkg::out_t            out_data_q;
  gcsc_pkg::out_t            result;
  logic [gcsc_pkg::LenW-1:0] dec_len;
  logic                      out_load;
  logic                      in_load;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  gcsc_len_dec u_len_dec (
    .opcode_i (in_data_q.command_word[gcsc_pkg::WordW-1 -: gcsc_pkg::OpW]),
    .length_o (dec_len)
  );

  gcsc_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_valid_q && out_load),
    .data_i    (in_data_q),
    .dec_len_i (dec_len),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
      if (out_load || !in_valid_q) begin
        in_valid_q <= in_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_data_q <= in_data_i;
    end
    if (out_load && in_valid_q) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/gcsc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcsc_checker: port-level checks for the command stream checker
// Observes the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module gcsc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire gcsc_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire gcsc_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_len_only_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_header |-> out_data_o.command_length == '0)
    else $error("length on non-header word");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.command_length <= gcsc_pkg::MaxLen)
    else $error("length out of range");

  a_unknown_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_header && out_data_o.command_length == '0
    |-> out_data_o.status == gcsc_pkg::ST_UNSUPPORTED)
    else $error("unknown opcode without unsupported verdict");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transfer changed while stalled");

endmodule

bind gpu_command_stream_checker gcsc_checker u_gcsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: gpu_command_stream_checker testbench
// Feeds short directed command streams, then random streams to ~1150 words in all:
// mostly well-framed commands, plus noise, unsupported opcodes and cut-short
// streams. Both sides idle at random. Each result transfer is checked against
// a cycle-free framing predictor kept in step with accepted input transfers.
// ----------------------------------------------------------------------------
module tb;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  gcsc_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  gcsc_pkg::out_t out_data_o;

  gpu_command_stream_checker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  gcsc_pkg::in_t     word_q[$];
  gcsc_pkg::out_t    verdict_q[$];
  logic [3:0]        words_left = 4'd0;
  gcsc_pkg::status_e err_hold   = gcsc_pkg::ST_OK;
  bit                in_taken;
  int                words_sent;
  int                results_seen;
  int                mismatches;

  always #2 clk_i = ~clk_i;

  function automatic logic [3:0] cmd_words(logic [7:0] op);
    int verts;
    int tex;
    int shade;
    if (op >= gcsc_pkg::OpPolyLo && op <= gcsc_pkg::OpPolyHi) begin
      verts = op[3] ? 4 : 3;
      tex   = int'(op[2]);
      shade = int'(op[4]);
      return 4'(1 + verts * (1 + tex + shade) - shade);
    end
    if (op >= gcsc_pkg::OpLineLo && op <= gcsc_pkg::OpLineHi) return 4'd3;
    if (op >= gcsc_pkg::OpPlineLo && op <= gcsc_pkg::OpPlineHi) return 4'd4;
    if (op >= gcsc_pkg::OpRectLo && op <= gcsc_pkg::OpRectHi)
      return 4'(2 + int'(op[2]) + (((op & gcsc_pkg::RectSizeM) == 8'h00) ? 1 : 0));
    if (op >= gcsc_pkg::OpEnvLo && op <= gcsc_pkg::OpEnvHi) return 4'd1;
    if (op == gcsc_pkg::OpNop) return 4'd1;
    if (op == gcsc_pkg::OpFill) return 4'd3;
    if (op == gcsc_pkg::OpCopy) return 4'd4;
    return 4'd0;
  endfunction

  function automatic gcsc_pkg::out_t frame_word(gcsc_pkg::in_t w);
    gcsc_pkg::out_t r;
    r = '0;
    r.stream_done = w.last_word;
    if (err_hold == gcsc_pkg::ST_OK) begin
      if (words_left != 4'd0) begin
        words_left = words_left - 4'd1;
      end else begin
        r.is_header      = 1'b1;
        r.command_length = cmd_words(w.command_word[31:24]);
        if (r.command_length == 4'd0) err_hold = gcsc_pkg::ST_UNSUPPORTED;
        else words_left = r.command_length - 4'd1;
      end
      if (w.last_word && err_hold == gcsc_pkg::ST_OK && words_left != 4'd0)
        err_hold = gcsc_pkg::ST_TRUNCATED;
    end
    r.status = err_hold;
    if (w.last_word) begin
      words_left = 4'd0;
      err_hold   = gcsc_pkg::ST_OK;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 7))
      0, 1: return 8'(gcsc_pkg::OpPolyLo + $urandom_range(0, 31));
      2: return 8'(gcsc_pkg::OpLineLo + $urandom_range(0, 7));
      3: return 8'(gcsc_pkg::OpPlineLo + $urandom_range(0, 7));
      4: return 8'(gcsc_pkg::OpRectLo + $urandom_range(0, 31));
      5: return 8'(gcsc_pkg::OpEnvLo + $urandom_range(0, 5));
      6: begin
        case ($urandom_range(0, 2))
          0: return gcsc_pkg::OpNop;
          1: return gcsc_pkg::OpFill;
          default: return gcsc_pkg::OpCopy;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_word(logic [31:0] w, logic last);
    gcsc_pkg::in_t t;
    t.command_word = w;
    t.last_word    = last;
    word_q.push_back(t);
  endtask

  task automatic push_cmd(logic [7:0] op, logic last);
    logic [3:0] len;
    len = cmd_words(op);
    push_word({op, 24'($urandom)}, last && len <= 4'd1);
    for (int i = 1; i < len; i++) push_word($urandom, last && i == len - 1);
  endtask

  // input accept and result check
  always @(posedge clk_i) begin
    gcsc_pkg::out_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        verdict_q.push_back(frame_word(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", out_data_o);
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.is_header !== want.is_header ||
              out_data_o.command_length !== want.command_length ||
              out_data_o.status !== want.status ||
              out_data_o.stream_done !== want.stream_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.is_header, want.command_length, want.status,
                       want.stream_done, out_data_o.is_header,
                       out_data_o.command_length, out_data_o.status,
                       out_data_o.stream_done);
          end
        end
      end
    end
  end

  // driver; words 400..649 run with no idling on either side
  always @(negedge clk_i) begin
    bit quiet_in;
    bit quiet_out;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_data_i   <= '0;
      out_stall_i <= 1'b0;
    end else begin
      quiet_in  = words_sent >= 400 && words_sent < 650;
      quiet_out = results_seen >= 400 && results_seen < 650;
      if (!in_valid_i || in_taken) begin
        if (word_q.size() > 0 && (quiet_in || $urandom_range(0, 99) >= 30)) begin
          in_data_i  <= word_q.pop_front();
          in_valid_i <= 1'b1;
          words_sent++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet_out && $urandom_range(0, 99) < 30;
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [31:0] stream_q[$];
    logic [7:0]  op;
    logic [3:0]  len;
    int          n_cmds;
    int          cut;
    rst_ni = 1'b0;

    // directed streams
    push_cmd(gcsc_pkg::OpNop, 1'b1);
    push_cmd(gcsc_pkg::OpEnvHi, 1'b0);
    push_cmd(gcsc_pkg::OpFill, 1'b1);
    push_cmd(gcsc_pkg::OpEnvLo, 1'b0);
    push_word(32'hffff_ffff, 1'b0);
    push_word(32'hffff_ffff, 1'b0);
    push_word(32'h0000_0000, 1'b1);
    push_word({gcsc_pkg::OpCopy, 24'h000000}, 1'b0);
    push_word($urandom, 1'b0);
    push_word($urandom, 1'b1);
    push_word({8'h01, 24'hffffff}, 1'b1);
    push_word({gcsc_pkg::OpLineLo, 24'h5a5a5a}, 1'b1);
    push_cmd(gcsc_pkg::OpRectLo, 1'b0);
    push_cmd(gcsc_pkg::OpRectHi, 1'b0);
    push_cmd(gcsc_pkg::OpPlineHi, 1'b1);

    // random streams
    while (word_q.size() < 1150) begin
      stream_q.delete();
      n_cmds = $urandom_range(1, 5);
      for (int c = 0; c < n_cmds; c++) begin
        if ($urandom_range(0, 19) == 0) begin
          stream_q.push_back($urandom);
        end else begin
          op  = pick_op();
          len = cmd_words(op);
          stream_q.push_back({op, 24'($urandom)});
          for (int i = 1; i < len; i++) stream_q.push_back($urandom);
        end
      end
      cut = stream_q.size();
      if (cut > 1 && $urandom_range(0, 5) == 0) cut = $urandom_range(1, cut - 1);
      for (int i = 0; i < cut; i++) push_word(stream_q[i], i == cut - 1);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (word_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
